[sv/lvp_pkg.sv]
// Shared constants and latencies for the Voigt profile pipeline.
`timescale 1ns / 1ps
package lvp_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGMA_SCALE = 2'd1;

   localparam logic [31:0] DAMPING_RESET     = 32'd2018634;
   localparam logic [31:0] SIGMA_SCALE_RESET = 32'd0;

   localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
   localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] EXP_LIMIT = 64'h0000_0040_0000_0000;
   localparam logic [63:0] Z_SHIFT_NUM = 64'd3672197038;
   localparam logic [63:0] Z_SHIFT_DEN = 64'd14688788152;
   localparam logic [63:0] WING_ADD    = 64'h0000_0015_0000_0000;
   localparam logic [63:0] POLY_C4 = 64'd6388356071425049;
   localparam logic [63:0] POLY_C3 = 64'd10366160442300039;
   localparam logic [63:0] POLY_C2 = 64'd4977603488151241;
   localparam logic [63:0] POLY_C1 = 64'd125763019594321;
   localparam logic [63:0] INV_SQRT_PI_Q50 = 64'd635220999557998;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   localparam int unsigned MUL_LAT       = 2;
   localparam int unsigned EXP_TERMS     = 20;
   localparam int unsigned EXP_SQUARINGS = 6;
   localparam int unsigned TERM_LAT      = 2 * MUL_LAT + 1;
   localparam int unsigned EXP_LAT = 1 + EXP_TERMS * TERM_LAT + EXP_SQUARINGS * MUL_LAT + 1;

   localparam int unsigned Z_FRAC_BITS  = 60;
   localparam int unsigned F1_FRAC_BITS = 50;
   localparam int unsigned F1_INT_BITS  = 5;
   localparam int unsigned F2_FRAC_BITS = 60;
   localparam int unsigned F1_ALIGN = Z_FRAC_BITS - (F1_FRAC_BITS + F1_INT_BITS);
   localparam int unsigned WING_TAIL = 7 * MUL_LAT + 2;
   localparam int unsigned WING_LAT = 1 + Z_FRAC_BITS + WING_TAIL + 1;

   localparam int unsigned TOTAL_LAT = EXP_LAT + 2 * MUL_LAT + 2;

endpackage

[sv/lya_voigt_profile_cross_section.sv]
// Top level of the Voigt profile and Lyman-alpha cross-section pipeline.
//
// Usage:
//   Input transactions carry a signed Q16.16 offset x on req_x_offset; each one
//   yields exactly one result transaction with H(x,a) in Q2.46 on rsp_h_value
//   and (sigma_scale * H) >> 46 on rsp_cross_section, both saturating.
//   The damping a and sigma_scale are loaded through csr_wr_en / csr_index /
//   csr_wr_data; write them only while no transaction is in flight.
//   Latency from acceptance to rsp_valid is set by the exponential path:
//   20 series terms of five stages each plus six two-stage squarings.
//   Throughput is one transaction per cycle; a new one is accepted every cycle
//   while the output register is empty or being taken.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   req_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and loads damping = 2018634, sigma_scale = 0.
`timescale 1ns / 1ps
module lya_voigt_profile_cross_section (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [31:0]                 req_x_offset,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [47:0]                        rsp_h_value,
   output logic [47:0]                        rsp_cross_section,
   input  logic                               csr_wr_en,
   input  logic [lvp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lvp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   localparam int unsigned LAT = lvp_pkg::TOTAL_LAT;

   logic [LAT-1:0] vld_ff, vld_in;
   logic           en;
   logic [31:0]    damping_ff, sigma_scale_ff;
   logic [31:0]    mag_ff, mag_in;
   logic [63:0]    s_ff, s_in;
   logic [63:0]    exp_val, wing_val, wing_d;
   logic [63:0]    h50;
   logic [59:0]    h60;
   logic [47:0]    h_ff, h_in, h_d;
   logic [63:0]    cs64;
   logic [47:0]    rsp_h_ff, rsp_cs_ff, rsp_cs_in;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff     <= lvp_pkg::DAMPING_RESET;
         sigma_scale_ff <= lvp_pkg::SIGMA_SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lvp_pkg::CSR_DAMPING:     damping_ff     <= csr_wr_data;
            lvp_pkg::CSR_SIGMA_SCALE: sigma_scale_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign mag_in = req_x_offset[31] ? (~req_x_offset + 32'd1) : req_x_offset;
   assign s_in   = 64'(mag_ff) * 64'(mag_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         s_ff   <= s_in;
      end
   end

   lvp_exp u_exp (.clock(clock), .en(en), .s(s_ff), .e(exp_val));

   lvp_wing u_wing (
      .clock(clock), .en(en), .s(s_ff), .damping(damping_ff), .w(wing_val)
   );

   lvp_dly #(.W(64), .N(lvp_pkg::EXP_LAT - lvp_pkg::WING_LAT)) u_dly_wing (
      .clock(clock), .en(en), .d(wing_val), .q(wing_d)
   );

   assign h50  = wing_d + (exp_val >> 10);
   assign h60  = h50[63:4];
   assign h_in = (h60[59:48] != '0) ? lvp_pkg::MAX48 : h60[47:0];

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff <= h_in;
      end
   end

   lvp_mul #(.SH(46)) u_mul_cs (
      .clock(clock), .en(en), .a({32'b0, sigma_scale_ff}), .b({16'b0, h_ff}), .y(cs64)
   );
   lvp_dly #(.W(48), .N(lvp_pkg::MUL_LAT)) u_dly_h (
      .clock(clock), .en(en), .d(h_ff), .q(h_d)
   );

   assign rsp_cs_in = (cs64[63:48] != '0) ? lvp_pkg::MAX48 : cs64[47:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_h_ff  <= h_d;
         rsp_cs_ff <= rsp_cs_in;
      end
   end

   assign rsp_valid         = vld_ff[LAT-1];
   assign rsp_h_value       = rsp_h_ff;
   assign rsp_cross_section = rsp_cs_ff;

`ifndef ASSERT_OFF
   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output register empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted transaction not tracked in first stage");
`endif
endmodule

[sv/lvp_mul.sv]
// Two-stage 64x64 multiplier returning a 64-bit slice of the product.
`timescale 1ns / 1ps
module lvp_mul #(
   parameter int unsigned SH = 60
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] y
);
   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [63:0]  pp00_in, pp01_in, pp10_in, pp11_in;
   logic [127:0] prod;
   logic [63:0]  y_ff;
   logic [63:0]  y_in;

   assign pp00_in = 64'(a[31:0]) * 64'(b[31:0]);
   assign pp01_in = 64'(a[31:0]) * 64'(b[63:32]);
   assign pp10_in = 64'(a[63:32]) * 64'(b[31:0]);
   assign pp11_in = 64'(a[63:32]) * 64'(b[63:32]);

   assign prod = {pp11_ff, pp00_ff} + {32'b0, pp01_ff, 32'b0} + {32'b0, pp10_ff, 32'b0};
   assign y_in = prod[SH+63:SH];

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= pp00_in;
         pp01_ff <= pp01_in;
         pp10_ff <= pp10_in;
         pp11_ff <= pp11_in;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;
endmodule

[sv/lvp_dly.sv]
// Enabled delay line for pipeline sideband data.
`timescale 1ns / 1ps
module lvp_dly #(
   parameter int unsigned W = 64,
   parameter int unsigned N = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] pipe_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[N-1];
endmodule

[sv/lvp_div.sv]
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^K / den).
`timescale 1ns / 1ps
module lvp_div #(
   parameter int unsigned K  = 60,
   parameter int unsigned IB = 0
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quo
);
   localparam int unsigned STEPS = K + IB;
   localparam int unsigned RW    = 65 + IB;

   logic [RW-1:0] r_ff  [STEPS];
   logic [RW-1:0] dd_ff [STEPS];
   logic [63:0]   q_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [RW-1:0] r_prev, dd_prev, shifted, r_in;
      logic [63:0]   q_prev, q_in;
      logic          ge;

      if (i == 0) begin : g_first
         assign r_prev  = RW'(num);
         assign dd_prev = RW'(den) << IB;
         assign q_prev  = '0;
      end else begin : g_rest
         assign r_prev  = r_ff[i-1];
         assign dd_prev = dd_ff[i-1];
         assign q_prev  = q_ff[i-1];
      end

      assign shifted = {r_prev[RW-2:0], 1'b0};
      assign ge      = shifted >= dd_prev;
      assign r_in    = ge ? shifted - dd_prev : shifted;
      assign q_in    = {q_prev[62:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i]  <= r_in;
            dd_ff[i] <= dd_prev;
            q_ff[i]  <= q_in;
         end
      end
   end

   assign quo = q_ff[STEPS-1];
endmodule

[sv/lvp_exp.sv]
// exp(-s) pipeline: Taylor series of exp(-s/64) followed by six squarings.
`timescale 1ns / 1ps
module lvp_exp (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] s,
   output logic [63:0] e
);
   localparam int unsigned NT = lvp_pkg::EXP_TERMS;
   localparam int unsigned NS = lvp_pkg::EXP_SQUARINGS;

   logic [63:0] u_ff, u_in;
   logic        big_ff, big_in;
   logic [63:0] term_c [NT+1];
   logic [63:0] sum_c  [NT+1];
   logic [63:0] u_c    [NT+1];
   logic        big_c  [NT+1];
   logic [63:0] sq_c   [NS+1];
   logic        sqbig_c [NS+1];
   logic [63:0] e_ff, e_in;

   assign u_in   = {s[41:0], 22'b0};
   assign big_in = s >= lvp_pkg::EXP_LIMIT;

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_in;
         big_ff <= big_in;
      end
   end

   assign term_c[0] = lvp_pkg::ONE_Q60;
   assign sum_c[0]  = lvp_pkg::ONE_Q60;
   assign u_c[0]    = u_ff;
   assign big_c[0]  = big_ff;

   for (genvar n = 1; n <= NT; n++) begin : g_term
      localparam logic [63:0] TERM_N = 64'(n);
      localparam logic [63:0] RECIP  = 64'hFFFF_FFFF_FFFF_FFFF / TERM_N;

      logic [63:0]  p, pd, q0, t_in, sum_in;
      logic [128:0] side1, side2;
      logic [7:0]   prod8, rem8;
      logic         fix;
      logic [63:0]  term_ff, sum_ff, uo_ff;
      logic         bigo_ff;

      lvp_mul #(.SH(60)) u_mul_p (
         .clock(clock), .en(en), .a(term_c[n-1]), .b(u_c[n-1]), .y(p)
      );
      lvp_dly #(.W(129), .N(lvp_pkg::MUL_LAT)) u_dly_s1 (
         .clock(clock), .en(en), .d({u_c[n-1], sum_c[n-1], big_c[n-1]}), .q(side1)
      );
      lvp_mul #(.SH(64)) u_mul_q (
         .clock(clock), .en(en), .a(p), .b(RECIP), .y(q0)
      );
      lvp_dly #(.W(64), .N(lvp_pkg::MUL_LAT)) u_dly_p (
         .clock(clock), .en(en), .d(p), .q(pd)
      );
      lvp_dly #(.W(129), .N(lvp_pkg::MUL_LAT)) u_dly_s2 (
         .clock(clock), .en(en), .d(side1), .q(side2)
      );

      // remainder stays below 2n, so the low byte settles the correction
      assign prod8 = q0[7:0] * TERM_N[7:0];
      assign rem8  = pd[7:0] - prod8;
      assign fix   = rem8 >= TERM_N[7:0];
      assign t_in  = q0 + 64'(fix);

      if (n % 2 == 1) begin : g_odd
         assign sum_in = side2[64:1] - t_in;
      end else begin : g_even
         assign sum_in = side2[64:1] + t_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            term_ff <= t_in;
            sum_ff  <= sum_in;
            uo_ff   <= side2[128:65];
            bigo_ff <= side2[0];
         end
      end

      assign term_c[n] = term_ff;
      assign sum_c[n]  = sum_ff;
      assign u_c[n]    = uo_ff;
      assign big_c[n]  = bigo_ff;
   end

   assign sq_c[0]    = sum_c[NT];
   assign sqbig_c[0] = big_c[NT];

   for (genvar k = 0; k < NS; k++) begin : g_sq
      lvp_mul #(.SH(60)) u_mul_sq (
         .clock(clock), .en(en), .a(sq_c[k]), .b(sq_c[k]), .y(sq_c[k+1])
      );
      lvp_dly #(.W(1), .N(lvp_pkg::MUL_LAT)) u_dly_big (
         .clock(clock), .en(en), .d(sqbig_c[k]), .q(sqbig_c[k+1])
      );
   end

   assign e_in = sqbig_c[NS] ? '0 : sq_c[NS];

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   assign e = e_ff;
endmodule

[sv/lvp_wing.sv]
// Voigt wing term q/sqrt(pi): three dividers, quartic and scaling products.
`timescale 1ns / 1ps
module lvp_wing (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] s,
   input  logic [31:0] damping,
   output logic [63:0] w
);
   localparam int unsigned ML = lvp_pkg::MUL_LAT;

   logic        core_ff, core_in, core_d;
   logic [63:0] zn_ff, zd_ff, f1n_ff, f1d_ff, f2d_ff;
   logic [63:0] z, z_d2, z_d4, z_d6, z2, z2_d4, z3, z3_d2, z4;
   logic [63:0] f1r, f1, f2, g1, g1_d, g2, g3, g4;
   logic [63:0] c1z, c2z, c3z, c4z;
   logic [63:0] pos_ff, pos_in, neg_ff, p_ff, p_in;
   logic [63:0] w_ff, w_in;

   assign core_in = s <= lvp_pkg::Z_SHIFT_NUM;

   always_ff @(posedge clock) begin
      if (en) begin
         core_ff <= core_in;
         zn_ff   <= s - lvp_pkg::Z_SHIFT_NUM;
         zd_ff   <= s + lvp_pkg::Z_SHIFT_DEN;
         f1n_ff  <= s + lvp_pkg::WING_ADD;
         f1d_ff  <= s;
         f2d_ff  <= s + lvp_pkg::ONE_Q32;
      end
   end

   lvp_div #(.K(lvp_pkg::Z_FRAC_BITS), .IB(0)) u_div_z (
      .clock(clock), .en(en), .num(zn_ff), .den(zd_ff), .quo(z)
   );
   lvp_div #(.K(lvp_pkg::F1_FRAC_BITS), .IB(lvp_pkg::F1_INT_BITS)) u_div_f1 (
      .clock(clock), .en(en), .num(f1n_ff), .den(f1d_ff), .quo(f1r)
   );
   lvp_div #(.K(lvp_pkg::F2_FRAC_BITS), .IB(0)) u_div_f2 (
      .clock(clock), .en(en), .num(lvp_pkg::ONE_Q32), .den(f2d_ff), .quo(f2)
   );
   lvp_dly #(.W(64), .N(lvp_pkg::F1_ALIGN)) u_dly_f1 (
      .clock(clock), .en(en), .d(f1r), .q(f1)
   );

   lvp_mul #(.SH(60)) u_mul_z2 (.clock(clock), .en(en), .a(z), .b(z), .y(z2));
   lvp_dly #(.W(64), .N(ML)) u_dly_z2 (.clock(clock), .en(en), .d(z), .q(z_d2));
   lvp_mul #(.SH(60)) u_mul_z3 (.clock(clock), .en(en), .a(z2), .b(z_d2), .y(z3));
   lvp_dly #(.W(64), .N(ML)) u_dly_z4 (.clock(clock), .en(en), .d(z_d2), .q(z_d4));
   lvp_mul #(.SH(60)) u_mul_z4 (.clock(clock), .en(en), .a(z3), .b(z_d4), .y(z4));
   lvp_dly #(.W(64), .N(ML)) u_dly_z6 (.clock(clock), .en(en), .d(z_d4), .q(z_d6));
   lvp_dly #(.W(64), .N(2*ML)) u_dly_z2b (.clock(clock), .en(en), .d(z2), .q(z2_d4));
   lvp_dly #(.W(64), .N(ML)) u_dly_z3b (.clock(clock), .en(en), .d(z3), .q(z3_d2));

   lvp_mul #(.SH(60)) u_mul_c4 (
      .clock(clock), .en(en), .a(lvp_pkg::POLY_C4), .b(z4), .y(c4z)
   );
   lvp_mul #(.SH(60)) u_mul_c3 (
      .clock(clock), .en(en), .a(lvp_pkg::POLY_C3), .b(z3_d2), .y(c3z)
   );
   lvp_mul #(.SH(60)) u_mul_c2 (
      .clock(clock), .en(en), .a(lvp_pkg::POLY_C2), .b(z2_d4), .y(c2z)
   );
   lvp_mul #(.SH(60)) u_mul_c1 (
      .clock(clock), .en(en), .a(lvp_pkg::POLY_C1), .b(z_d6), .y(c1z)
   );

   assign pos_in = c4z + c2z + c1z;
   assign p_in   = (pos_ff > neg_ff) ? pos_ff - neg_ff : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         neg_ff <= c3z;
         p_ff   <= p_in;
      end
   end

   lvp_mul #(.SH(60)) u_mul_g1 (.clock(clock), .en(en), .a(f1), .b(f2), .y(g1));
   lvp_dly #(.W(64), .N(3*ML+2)) u_dly_g1 (.clock(clock), .en(en), .d(g1), .q(g1_d));
   lvp_mul #(.SH(50)) u_mul_g2 (.clock(clock), .en(en), .a(g1_d), .b(p_ff), .y(g2));
   lvp_mul #(.SH(32)) u_mul_g3 (
      .clock(clock), .en(en), .a(g2), .b({32'b0, damping}), .y(g3)
   );
   lvp_mul #(.SH(50)) u_mul_g4 (
      .clock(clock), .en(en), .a(g3), .b(lvp_pkg::INV_SQRT_PI_Q50), .y(g4)
   );

   lvp_dly #(.W(1), .N(lvp_pkg::Z_FRAC_BITS + lvp_pkg::WING_TAIL)) u_dly_core (
      .clock(clock), .en(en), .d(core_ff), .q(core_d)
   );

   assign w_in = core_d ? '0 : g4;

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
      end
   end

   assign w = w_ff;
endmodule

[sim/tb_lya_voigt_profile_cross_section.sv]
// Testbench for the Voigt profile and cross-section pipeline with a built-in bit-exact predictor.
`timescale 1ns / 1ps
module tb_lya_voigt_profile_cross_section;

   localparam logic [lvp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [lvp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_x_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [47:0] rsp_h_value;
   logic [47:0] rsp_cross_section;
   logic csr_wr_en = 1'b0;
   logic [lvp_pkg::CSR_INDEX_W-1:0] csr_index = lvp_pkg::CSR_DAMPING;
   logic [lvp_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   typedef struct packed {
      logic [47:0] h_value;
      logic [47:0] cross_section;
   } profile_type;

   profile_type expected_profiles[$];
   logic [31:0] damping_now = lvp_pkg::DAMPING_RESET;
   logic [31:0] sigma_now = lvp_pkg::SIGMA_SCALE_RESET;
   bit steady = 1'b0;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;

   lya_voigt_profile_cross_section dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> sh);
   endfunction

   function automatic logic [63:0] div_frac(logic [63:0] n, logic [63:0] d, int k);
      logic [127:0] t;
      t = 128'(n) << k;
      return 64'(t / 128'(d));
   endfunction

   function automatic logic [63:0] exp_neg_q60(logic [63:0] s);
      logic [63:0] u, term, sum;
      term = lvp_pkg::ONE_Q60;
      sum = lvp_pkg::ONE_Q60;
      if (s >= lvp_pkg::EXP_LIMIT) return 64'd0;
      u = s << 22;
      for (int n = 1; n <= lvp_pkg::EXP_TERMS; n++) begin
         term = mul_shr(term, u, 60) / 64'(n);
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      for (int n = 0; n < lvp_pkg::EXP_SQUARINGS; n++) sum = mul_shr(sum, sum, 60);
      return sum;
   endfunction

   function automatic logic [63:0] wing_q50(logic [63:0] s, logic [63:0] a);
      logic [63:0] z, z2, z3, z4, pos, neg, p, f1, f2, g;
      if (s <= lvp_pkg::Z_SHIFT_NUM) return 64'd0;
      z = div_frac(s - lvp_pkg::Z_SHIFT_NUM, s + lvp_pkg::Z_SHIFT_DEN, 60);
      z2 = mul_shr(z, z, 60);
      z3 = mul_shr(z2, z, 60);
      z4 = mul_shr(z3, z, 60);
      pos = mul_shr(lvp_pkg::POLY_C4, z4, 60) + mul_shr(lvp_pkg::POLY_C2, z2, 60)
            + mul_shr(lvp_pkg::POLY_C1, z, 60);
      neg = mul_shr(lvp_pkg::POLY_C3, z3, 60);
      p = (pos > neg) ? pos - neg : 64'd0;
      f1 = div_frac(s + lvp_pkg::WING_ADD, s, 50);
      f2 = div_frac(lvp_pkg::ONE_Q32, s + lvp_pkg::ONE_Q32, 60);
      g = mul_shr(f1, f2, 60);
      g = mul_shr(g, p, 50);
      g = mul_shr(g, a, 32);
      return mul_shr(g, lvp_pkg::INV_SQRT_PI_Q50, 50);
   endfunction

   function automatic profile_type predict_profile(logic [31:0] x);
      logic [63:0] mag, s, h, cs;
      profile_type r;
      mag = x[31] ? (64'd1 << 32) - 64'(x) : 64'(x);
      s = mag * mag;
      h = (wing_q50(s, 64'(damping_now)) + (exp_neg_q60(s) >> 10)) >> 4;
      if (h > 64'(lvp_pkg::MAX48)) h = 64'(lvp_pkg::MAX48);
      cs = mul_shr(64'(sigma_now), h, 46);
      if (cs > 64'(lvp_pkg::MAX48)) cs = 64'(lvp_pkg::MAX48);
      r.h_value = h[47:0];
      r.cross_section = cs[47:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   task automatic send_offset(logic signed [31:0] x);
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_offset <= x;
      do @(posedge clock); while (req_stall);
      expected_profiles.push_back(predict_profile(x));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_profiles.size() != 0) @(negedge clock);
      repeat (lvp_pkg::TOTAL_LAT + 10) @(negedge clock);
   endtask

   task automatic write_csr(logic [lvp_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == lvp_pkg::CSR_DAMPING) damping_now = data;
      else if (idx == lvp_pkg::CSR_SIGMA_SCALE) sigma_now = data;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_offset();
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: return $signed($urandom_range(131072)) - 32'sd65536;
         default: return $signed($urandom_range(1048576)) - 32'sd524288;
      endcase
   endfunction

   always @(negedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 35);

   always @(posedge clock) begin
      profile_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_profiles.size() == 0) begin
            report_mismatch("unexpected result", rsp_h_value, 48'd0);
         end else begin
            want = expected_profiles.pop_front();
            if (rsp_h_value != want.h_value)
               report_mismatch("h_value", rsp_h_value, want.h_value);
            if (rsp_cross_section != want.cross_section)
               report_mismatch("cross_section", rsp_cross_section, want.cross_section);
         end
      end
   end

   task automatic test_directed;
      logic signed [31:0] pts[20] = '{
         32'sd0, 32'sd1, -32'sd1, 32'sd65536, -32'sd65536, 32'sd60598, 32'sd60599,
         32'sd60600, -32'sd60600, 32'sd131072, 32'sd524288, 32'sd524289,
         32'sd655360, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, 32'sd6553600,
         32'sd98304, -32'sd200000, 32'sd20000};
      write_csr(lvp_pkg::CSR_SIGMA_SCALE, 32'd123456789);
      foreach (pts[i]) send_offset(pts[i]);
      drain();
   endtask

   task automatic test_config_extremes;
      logic [31:0] dmp[4] = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'h80000000};
      logic [31:0] sig[4] = '{32'hFFFFFFFF, 32'd0, 32'd1, 32'h00010000};
      for (int k = 0; k < 4; k++) begin
         write_csr(lvp_pkg::CSR_DAMPING, dmp[k]);
         write_csr(lvp_pkg::CSR_SIGMA_SCALE, sig[k]);
         write_csr(CSR_SPARE_A, $urandom);
         write_csr(CSR_SPARE_B, $urandom);
         repeat (6) send_offset(pick_offset());
         send_offset(32'sd0);
         send_offset(32'sd65536);
         drain();
      end
   endtask

   task automatic test_random;
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(lvp_pkg::CSR_DAMPING, (ph == 4) ? lvp_pkg::DAMPING_RESET : $urandom);
         write_csr(lvp_pkg::CSR_SIGMA_SCALE, $urandom);
         steady = (ph == 2);
         repeat (120) send_offset(pick_offset());
         drain();
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_config_extremes();
      test_random();
      $display("covered %0d results over directed offsets, register extremes",
               results_seen);
      $display("and random phases with and without stalls");
      if (mismatches == 0 && expected_profiles.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
